// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/lfr8_pkg.sv -----
// ----------------------------------------------------------------------------
// lfr8_pkg
// Shared constants, types and helpers of the 8x8 loop filter reconstruction.
// ----------------------------------------------------------------------------
`default_nettype none

package lfr8_pkg;

  localparam int BLOCK_DIM = 8;
  localparam int NPIX      = BLOCK_DIM * BLOCK_DIM;
  localparam int PIX_W     = 8;
  localparam int RES_W     = 16;
  localparam int ROW_W     = BLOCK_DIM * PIX_W;
  localparam int COL_W     = $clog2(BLOCK_DIM);
  localparam int IDX_W     = $clog2(NPIX);
  // Rows shifted into the window: the full block plus one flush shift.
  localparam int FETCH_W   = $clog2(BLOCK_DIM + 2);

  localparam logic [COL_W-1:0]   DIM_LAST   = COL_W'(BLOCK_DIM - 1);
  localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(NPIX - 1);
  localparam logic [FETCH_W-1:0] FETCH_DONE = FETCH_W'(BLOCK_DIM + 1);
  localparam logic [FETCH_W-1:0] WIN_LAG    = FETCH_W'(2);

  // Rounding offsets and the output ceiling.
  localparam logic [11:0]        RND_INT  = 12'd8;
  localparam logic [9:0]         RND_EDGE = 10'd2;
  localparam logic [PIX_W-1:0]   PIX_MAX  = PIX_W'(255);

  typedef enum logic [1:0] {
    S_LOAD,
    S_READ,
    S_SHIFT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic              load;
    logic [IDX_W-1:0]  load_idx;
    logic              rd;
    logic [COL_W-1:0]  rd_row;
    logic              shift;
    logic              emit;
    logic [COL_W-1:0]  emit_row;
    logic [COL_W-1:0]  emit_col;
    logic              emit_last;
  } cmd_t;

  function automatic logic [PIX_W-1:0] pix_at(input logic [ROW_W-1:0] word,
                                              input logic [COL_W-1:0] col);
    return word[int'(col) * PIX_W +: PIX_W];
  endfunction

endpackage

`default_nettype wire

// ----- src/loop_filter_reconstruct_8x8_core.sv -----
// ----------------------------------------------------------------------------
// loop_filter_reconstruct_8x8_core
// 8x8 predictor loop filter (separable 1-2-1) with residual reconstruction.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: present ref_pixel_i, residual_i and coded_i with
//   start_i; a request is taken at a rising edge where start_i is high and
//   busy_o is low. Send the 64 pixels of a block in raster order; coded_i is
//   sampled from the first request of each block only.
//   Result channel: each result is on out_pixel_o for one cycle, marked by
//   strobe_o; last_o flags the 64th. The receiver cannot stall, so results
//   leave at a fixed schedule.
//   Timing: a pixel can be loaded every cycle while busy_o is low. After the
//   64th request busy_o is high during the filter pass: the pixel row memory
//   delivers one row per read, and each row costs a read, a window shift and
//   the filtering of its eight pixels. The first result passes the filter
//   and output registers once two rows are in the window, the last one
//   appears in the cycle after busy_o falls; the next block may already load then.
//   Reset: clears the sequencer, the coded flag and the result flags; the
//   stores are not cleared, and every entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module loop_filter_reconstruct_8x8_core
  import lfr8_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [PIX_W-1:0]        ref_pixel_i,
  input  wire logic signed [RES_W-1:0] residual_i,
  input  wire logic                    coded_i,
  output logic                         strobe_o,
  output logic [PIX_W-1:0]             out_pixel_o,
  output logic                         last_o
);

  // Sequencer commands into the datapath.
  cmd_t cmd;

  // Walk load, row fetch and column emit.
  lfr8_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // Hold the stores, filter the window and drive the result registers.
  lfr8_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .ref_pixel_i (ref_pixel_i),
    .residual_i  (residual_i),
    .coded_i     (coded_i),
    .out_pixel_o (out_pixel_o),
    .last_o      (last_o),
    .strobe_o    (strobe_o)
  );

endmodule

`default_nettype wire

// ----- src/lfr8_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfr8_ctrl
// Sequencer: load count, row fetch count and column walk of the filter pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr8_ctrl
  import lfr8_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  output cmd_t      cmd_o
);

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    load_cnt_q, load_cnt_d;
  logic [FETCH_W-1:0]  fetch_cnt_q, fetch_cnt_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [FETCH_W-1:0]  emit_row_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      load_cnt_q  <= '0;
      fetch_cnt_q <= '0;
      col_q       <= '0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      fetch_cnt_q <= fetch_cnt_d;
      col_q       <= col_d;
    end
  end

  // The emitted row trails the rows shifted into the window by two.
  assign emit_row_full = fetch_cnt_q - WIN_LAG;

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    fetch_cnt_d = fetch_cnt_q;
    col_d       = col_q;
    busy_o      = 1'b1;
    cmd_o       = '0;
    cmd_o.load_idx  = load_cnt_q;
    cmd_o.rd_row    = fetch_cnt_q[COL_W-1:0];
    cmd_o.emit_row  = emit_row_full[COL_W-1:0];
    cmd_o.emit_col  = col_q;
    unique case (state_q)
      S_LOAD: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          load_cnt_d = load_cnt_q + 1'b1;
          if (load_cnt_q == IDX_LAST) begin
            fetch_cnt_d = '0;
            state_d     = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        fetch_cnt_d = fetch_cnt_q + 1'b1;
        col_d       = '0;
        // The first row only primes the window; fetch the second one too.
        state_d     = (fetch_cnt_q == '0) ? S_READ : S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_last = (cmd_o.emit_row == DIM_LAST) && (col_q == DIM_LAST);
        col_d           = col_q + 1'b1;
        if (col_q == DIM_LAST) begin
          state_d = (fetch_cnt_q == FETCH_DONE) ? S_LOAD : S_READ;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/lfr8_dp.sv -----
// ----------------------------------------------------------------------------
// lfr8_dp
// Datapath: pixel row memory, residual memory, three-row window, 1-2-1
// filter stage and residual add with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr8_dp
  import lfr8_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cmd_t                    cmd_i,
  input  wire logic [PIX_W-1:0]        ref_pixel_i,
  input  wire logic signed [RES_W-1:0] residual_i,
  input  wire logic                    coded_i,
  output logic [PIX_W-1:0]             out_pixel_o,
  output logic                         last_o,
  output logic                         strobe_o
);

  logic [ROW_W-1:0]        pix_mem [BLOCK_DIM];
  logic [RES_W-1:0]        res_mem [NPIX];

  logic [ROW_W-PIX_W-1:0]  row_buf_q;
  logic [ROW_W-1:0]        rd_word_q;
  logic [ROW_W-1:0]        win0_q, win1_q, win2_q;
  logic [RES_W-1:0]        res_q;
  logic                    coded_q;

  logic [PIX_W-1:0]        filt_q;
  logic                    v1_q, last1_q, coded1_q;
  logic [PIX_W-1:0]        out_q;
  logic                    strobe_q, last_q;

  logic [COL_W-1:0]        load_col;
  logic [COL_W-1:0]        col_m, col_p;
  logic [9:0]              vs_m, vs_c, vs_p, hsum;
  logic [11:0]             isum;
  logic [9:0]              vsum_r;
  logic                    redge, cedge;
  logic [PIX_W-1:0]        filt_d;
  logic signed [RES_W:0]   sum_s;
  logic [PIX_W-1:0]        out_d;

  assign load_col = cmd_i.load_idx[COL_W-1:0];

  // Memories: one row write per eight pixels, one residual per pixel.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_mem[cmd_i.load_idx] <= residual_i;
      if (load_col == DIM_LAST) begin
        pix_mem[cmd_i.load_idx[IDX_W-1:COL_W]] <= {ref_pixel_i, row_buf_q};
      end else begin
        row_buf_q[int'(load_col) * PIX_W +: PIX_W] <= ref_pixel_i;
      end
    end
    if (cmd_i.rd) begin
      rd_word_q <= pix_mem[cmd_i.rd_row];
    end
    if (cmd_i.emit) begin
      res_q <= res_mem[{cmd_i.emit_row, cmd_i.emit_col}];
    end
  end

  // Advance the row window.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      win0_q <= win1_q;
      win1_q <= win2_q;
      win2_q <= rd_word_q;
    end
  end

  // Filter on the window; wrapped neighbor columns are used only where
  // the position is not on that border.
  function automatic logic [9:0] vsum(input logic [ROW_W-1:0] a,
                                     input logic [ROW_W-1:0] b,
                                     input logic [ROW_W-1:0] c,
                                     input logic [COL_W-1:0] col);
    return {2'b00, pix_at(a, col)} + {1'b0, pix_at(b, col), 1'b0}
         + {2'b00, pix_at(c, col)};
  endfunction

  always_comb begin
    col_m  = cmd_i.emit_col - 1'b1;
    col_p  = cmd_i.emit_col + 1'b1;
    vs_m   = vsum(win0_q, win1_q, win2_q, col_m);
    vs_c   = vsum(win0_q, win1_q, win2_q, cmd_i.emit_col);
    vs_p   = vsum(win0_q, win1_q, win2_q, col_p);
    isum   = {2'b00, vs_m} + {1'b0, vs_c, 1'b0} + {2'b00, vs_p} + RND_INT;
    hsum   = vsum(win1_q, win1_q, win1_q, '0) & '0;
    hsum   = {2'b00, pix_at(win1_q, col_m)} + {1'b0, pix_at(win1_q, cmd_i.emit_col), 1'b0}
           + {2'b00, pix_at(win1_q, col_p)} + RND_EDGE;
    vsum_r = vs_c + RND_EDGE;
    redge  = (cmd_i.emit_row == '0) || (cmd_i.emit_row == DIM_LAST);
    cedge  = (cmd_i.emit_col == '0) || (cmd_i.emit_col == DIM_LAST);
    if (redge && cedge) begin
      filt_d = pix_at(win1_q, cmd_i.emit_col);
    end else if (redge) begin
      filt_d = hsum[9:2];
    end else if (cedge) begin
      filt_d = vsum_r[9:2];
    end else begin
      filt_d = isum[11:4];
    end
  end

  // Residual add and saturation.
  always_comb begin
    sum_s = signed'({{(RES_W + 1 - PIX_W){1'b0}}, filt_q}) + {res_q[RES_W-1], res_q};
    if (!coded1_q) begin
      out_d = filt_q;
    end else if (sum_s < 0) begin
      out_d = '0;
    end else if (sum_s > signed'({{(RES_W + 1 - PIX_W){1'b0}}, PIX_MAX})) begin
      out_d = PIX_MAX;
    end else begin
      out_d = sum_s[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      filt_q <= filt_d;
    end
    if (v1_q) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coded_q  <= 1'b0;
      v1_q     <= 1'b0;
      last1_q  <= 1'b0;
      coded1_q <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      if (cmd_i.load && (cmd_i.load_idx == '0)) begin
        coded_q <= coded_i;
      end
      v1_q     <= cmd_i.emit;
      last1_q  <= cmd_i.emit_last;
      if (cmd_i.emit) begin
        coded1_q <= coded_q;
      end
      strobe_q <= v1_q;
      last_q   <= v1_q && last1_q;
    end
  end

  assign out_pixel_o = out_q;
  assign last_o      = last_q;
  assign strobe_o    = strobe_q;

endmodule

`default_nettype wire

// ----- src/lfr8_checker.sv -----
// ----------------------------------------------------------------------------
// lfr8_checker
// Port-level checks of the loop filter core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lfr8_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic strobe_o,
  input wire logic last_o
);

  // The last marker only rides on a result.
  `ASSERT_IMPL(a_last_on_strobe, clk_i, rst_ni, last_o, strobe_o)

  // A new block needs 64 requests, so nothing follows the last result.
  `ASSERT_NEXT(a_gap_after_last, clk_i, rst_ni, last_o, !strobe_o)

  // The filter pass only starts off a taken request.
  `ASSERT_IMPL(a_busy_from_req, clk_i, rst_ni, $rose(busy_o), $past(start_i))

  // The final result drains right after the filter pass ends.
  `ASSERT_NEXT(a_last_after_pass, clk_i, rst_ni, $fell(busy_o), last_o)

endmodule

bind loop_filter_reconstruct_8x8_core lfr8_checker u_lfr8_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .strobe_o (strobe_o),
  .last_o   (last_o)
);

`default_nettype wire
